// ----- rtl/b64gd_pkg.sv -----
`timescale 1ns / 1ps

package b64gd_pkg;

   // character codes
   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   localparam int unsigned LANES = 4;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_CHAR   = 2'd1,
      ST_BAD_PAD    = 2'd2,
      ST_SUPPRESSED = 2'd3
   } status_type;

   // one input item: a four-character group
   typedef struct packed {
      logic [7:0] char0;
      logic [7:0] char1;
      logic [7:0] char2;
      logic [7:0] char3;
      logic       final_group;
   } req_payload_type;

   // one result item
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] num_bytes;
      status_type status;
      logic [1:0] error_position;
      logic       text_end;
   } rsp_payload_type;

   // what one lane finds about its character
   typedef struct packed {
      logic [5:0] sextet;
      logic       is_pad;
      logic       is_bad;
   } lane_type;

endpackage

// ----- rtl/b64gd_if.sv -----
`timescale 1ns / 1ps

// request channel
interface b64gd_req_if;
   logic                      valid;
   logic                      ready;
   b64gd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// response channel
interface b64gd_rsp_if;
   logic                      valid;
   logic                      ready;
   b64gd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/b64gd_lane.sv -----
`timescale 1ns / 1ps

module b64gd_lane (
   input  logic [7:0]          char_code,
   output b64gd_pkg::lane_type lane
);

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] digit_off;

   // offsets into the alphabet ranges
   assign upper_off = char_code - 8'h41;
   assign lower_off = char_code - 8'h47;
   assign digit_off = char_code + 8'h04;

   // classify the character
   always_comb begin
      lane.sextet = 6'd0;
      lane.is_pad = 1'b0;
      lane.is_bad = 1'b0;
      if (char_code >= 8'h41 && char_code <= 8'h5A) begin
         lane.sextet = upper_off[5:0];
      end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
         lane.sextet = lower_off[5:0];
      end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
         lane.sextet = digit_off[5:0];
      end else if (char_code == b64gd_pkg::PLUS_CHAR) begin
         lane.sextet = 6'd62;
      end else if (char_code == b64gd_pkg::SLASH_CHAR) begin
         lane.sextet = 6'd63;
      end else if (char_code == b64gd_pkg::PAD_CHAR) begin
         lane.is_pad = 1'b1;
      end else begin
         lane.is_bad = 1'b1;
      end
   end

endmodule

// ----- rtl/b64gd_merge.sv -----
`timescale 1ns / 1ps

module b64gd_merge (
   input  b64gd_pkg::lane_type        lanes [b64gd_pkg::LANES],
   input  logic                       final_group,
   input  logic                       text_failed,
   output b64gd_pkg::rsp_payload_type result,
   output logic                       group_error
);

   logic [b64gd_pkg::LANES-1:0] pad_fault;
   logic [b64gd_pkg::LANES-1:0] any_fault;
   logic [23:0]                 quad;
   logic [1:0]                  pads;
   logic                        found;
   logic [1:0]                  first_pos;
   b64gd_pkg::status_type       first_status;

   // per-lane fault flags, padding only legal at the end of the final group
   always_comb begin
      for (int j = 0; j < b64gd_pkg::LANES; j++) begin
         pad_fault[j] = lanes[j].is_pad && (!final_group || j < 2 ||
                        (j == 2 && !lanes[3].is_pad));
         any_fault[j] = pad_fault[j] || lanes[j].is_bad;
      end
   end

   // first faulty position in scan order
   always_comb begin
      found        = 1'b0;
      first_pos    = 2'd0;
      first_status = b64gd_pkg::ST_OK;
      for (int j = 0; j < b64gd_pkg::LANES; j++) begin
         if (!found && any_fault[j]) begin
            found        = 1'b1;
            first_pos    = 2'(j);
            first_status = lanes[j].is_bad ? b64gd_pkg::ST_BAD_CHAR
                                           : b64gd_pkg::ST_BAD_PAD;
         end
      end
   end

   assign quad = {lanes[0].sextet, lanes[1].sextet, lanes[2].sextet, lanes[3].sextet};
   assign pads = {1'b0, lanes[2].is_pad} + {1'b0, lanes[3].is_pad};

   // combine into one result
   always_comb begin
      result.byte0          = 8'd0;
      result.byte1          = 8'd0;
      result.byte2          = 8'd0;
      result.num_bytes      = 2'd0;
      result.status         = b64gd_pkg::ST_OK;
      result.error_position = 2'd0;
      result.text_end       = final_group;
      group_error           = 1'b0;
      if (text_failed) begin
         result.status = b64gd_pkg::ST_SUPPRESSED;
      end else if (found) begin
         result.status         = first_status;
         result.error_position = first_pos;
         group_error           = 1'b1;
      end else begin
         result.num_bytes = 2'd3 - pads;
         result.byte0     = quad[23:16];
         if (pads < 2'd2) begin
            result.byte1 = quad[15:8];
         end
         if (pads == 2'd0) begin
            result.byte2 = quad[7:0];
         end
      end
   end

endmodule

// ----- rtl/base64_group_decoder_top.sv -----
`timescale 1ns / 1ps

// Base64 group decoder, standard alphabet.
// req_ch carries one four-character group per item with a final_group flag
// marking the end of a text; rsp_ch returns exactly one result per group:
// up to three bytes, the byte count, a status code, the first faulty position
// and an echo of the final flag.
// Four character lanes classify the group in parallel and a merge stage
// picks the first fault and packs the bytes.
// Each result is registered in the output register or in the skid register.
// Throughput: one group per cycle unless rsp_ch stalls; the only state carried
// between groups is the one-bit failed-text flag, updated in the cycle a group
// is taken. When rsp_ch stalls, one more group is taken into a skid register,
// and req_ch.ready then drops until the receiver drains the output register.
// Reset (synchronous, active high) empties both result registers and clears
// the failed-text flag; it takes effect at the next clock edge.

module base64_group_decoder_top (
   input  logic               clock,
   input  logic               reset,
   b64gd_req_if.sink          req_ch,
   b64gd_rsp_if.source        rsp_ch
);

   b64gd_pkg::lane_type        lanes [b64gd_pkg::LANES];
   b64gd_pkg::rsp_payload_type result;
   logic                       group_error;

   logic                       text_failed_ff, text_failed_in;
   logic                       out_valid_ff, out_valid_in;
   b64gd_pkg::rsp_payload_type out_data_ff, out_data_in;
   logic                       skid_valid_ff, skid_valid_in;
   b64gd_pkg::rsp_payload_type skid_data_ff, skid_data_in;

   logic accept;
   logic pop;

   // character lanes
   b64gd_lane u_lane0 (.char_code(req_ch.payload.char0), .lane(lanes[0]));
   b64gd_lane u_lane1 (.char_code(req_ch.payload.char1), .lane(lanes[1]));
   b64gd_lane u_lane2 (.char_code(req_ch.payload.char2), .lane(lanes[2]));
   b64gd_lane u_lane3 (.char_code(req_ch.payload.char3), .lane(lanes[3]));

   // merge lanes into one result
   b64gd_merge u_merge (
      .lanes       (lanes),
      .final_group (req_ch.payload.final_group),
      .text_failed (text_failed_ff),
      .result      (result),
      .group_error (group_error)
   );

   assign req_ch.ready   = !skid_valid_ff;
   assign accept         = req_ch.valid && req_ch.ready;
   assign pop            = out_valid_ff && rsp_ch.ready;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   // sticky error flag, cleared by the final group
   always_comb begin
      text_failed_in = text_failed_ff;
      if (accept) begin
         if (req_ch.payload.final_group) begin
            text_failed_in = 1'b0;
         end else if (group_error) begin
            text_failed_in = 1'b1;
         end
      end
   end

   // output register plus skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_failed_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         text_failed_ff <= text_failed_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid stage only holds an item behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid item without output item");

   // a final group always leaves the flag clear
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.payload.final_group) |=> !text_failed_ff)
      else $error("failed flag survived final group");

   // a suppressed group keeps the text failed unless it is final
   a_flag_sticks: assert property (@(posedge clock) disable iff (reset)
      (accept && text_failed_ff && !req_ch.payload.final_group) |=> text_failed_ff)
      else $error("failed flag dropped inside text");

   // a stalled output item holds
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("stalled result changed");

   // error results carry no bytes
   a_error_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status != b64gd_pkg::ST_OK)
         |-> (out_data_ff.num_bytes == 2'd0 && out_data_ff.byte0 == 8'd0))
      else $error("error result with bytes");

endmodule
